// ===== rtl/tgi_pkg.sv =====
// ----------------------------------------------------------------------------
// tgi_pkg: shared constants and types of the trilinear grid interpolator
// Grid geometry, sample width, register indexes, blend tags and the
// status structs that pass between the axis, blend and top modules.
// ----------------------------------------------------------------------------
package tgi_pkg;

  // grid geometry
  localparam int GRID_X      = 16;
  localparam int GRID_Y      = 16;
  localparam int GRID_Z      = 16;
  localparam int VALUE_WIDTH = 32;

  // stored sample width: low bits of the load word, read back sign-extended
  localparam int SAMPLE_W   = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int GRID_WORDS = GRID_X * GRID_Y * GRID_Z;
  localparam int ADDR_W     = $clog2(GRID_WORDS);

  // cell index fits 8 bits for any axis up to 256 points
  localparam int CELL_W   = 8;
  // fraction weight 0..65536
  localparam int FRAC_W   = 17;
  localparam int ONE_Q16  = 65536;

  // fixed field widths
  localparam int COORD_W  = 32;
  localparam int INDEX_W  = 12;
  localparam int CFG_IDX_W = 3;

  // input commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_Z = 3'd5;

  // blend tags: four z blends, two y blends, one x blend
  localparam int TAG_W = 3;
  localparam logic [TAG_W-1:0] TAG_Z0 = 3'd0;
  localparam logic [TAG_W-1:0] TAG_Z1 = 3'd1;
  localparam logic [TAG_W-1:0] TAG_Z2 = 3'd2;
  localparam logic [TAG_W-1:0] TAG_Z3 = 3'd3;
  localparam logic [TAG_W-1:0] TAG_Y0 = 3'd4;
  localparam logic [TAG_W-1:0] TAG_Y1 = 3'd5;
  localparam logic [TAG_W-1:0] TAG_X  = 3'd6;

  // per-axis mapping result
  typedef struct packed {
    logic              valid;
    logic [CELL_W-1:0] base;
    logic [FRAC_W-1:0] frac;
    logic              clamp;
  } axis_res_t;

  // blend request / response control
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } blend_ctl_t;

endpackage

// ===== rtl/tgi_axis.sv =====
// ----------------------------------------------------------------------------
// tgi_axis: coordinate to cell index and fraction for one axis
// Four-stage pipeline: offset and magnitude, split partial products,
// product sum, clamp to the grid. Result holds until the next start.
// ----------------------------------------------------------------------------
module tgi_axis (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [tgi_pkg::COORD_W-1:0] coord,
  input  logic signed [tgi_pkg::COORD_W-1:0] origin,
  input  logic [tgi_pkg::COORD_W-1:0]        inv_step,
  input  logic [tgi_pkg::CELL_W-1:0]         max_cell,
  output tgi_pkg::axis_res_t                 res
);
  import tgi_pkg::*;

  logic               v1, v2, v3;
  logic signed [32:0] d_next;
  logic [32:0]        mag;
  logic               neg1, neg2, neg3;
  logic [31:0]        pp_ll, pp_lh;
  logic [32:0]        pp_hl, pp_hh;
  logic [64:0]        p_next;
  logic [64:0]        p;
  logic [32:0]        ci;

  // stage 1: signed offset and its magnitude
  assign d_next = $signed({coord[COORD_W-1], coord}) - $signed({origin[COORD_W-1], origin});

  always_ff @(posedge clk) begin
    if (start) begin
      neg1 <= d_next[32];
      mag  <= d_next[32] ? 33'(-d_next) : 33'(d_next);
    end
  end

  // stage 2: 17x16 / 16x16 partial products
  always_ff @(posedge clk) begin
    if (v1) begin
      pp_ll <= mag[15:0] * inv_step[15:0];
      pp_lh <= mag[15:0] * inv_step[31:16];
      pp_hl <= mag[32:16] * inv_step[15:0];
      pp_hh <= mag[32:16] * inv_step[31:16];
      neg2  <= neg1;
    end
  end

  // stage 3: full Q33.32 position magnitude
  assign p_next = (65'(pp_hh) << 32) + (65'(pp_lh) << 16) + (65'(pp_hl) << 16)
                + 65'(pp_ll);

  always_ff @(posedge clk) begin
    if (v2) begin
      p    <= p_next;
      neg3 <= neg2;
    end
  end

  // stage 4: clamp below and beyond the grid; stage valids
  assign ci = p[64:32];

  always_ff @(posedge clk) begin
    if (v3) begin
      if (neg3 && (p != 65'd0)) begin
        res.base  <= '0;
        res.frac  <= '0;
        res.clamp <= 1'b1;
      end else if (ci > 33'(max_cell)) begin
        res.base  <= max_cell;
        res.frac  <= FRAC_W'(ONE_Q16);
        res.clamp <= 1'b1;
      end else begin
        res.base  <= ci[CELL_W-1:0];
        res.frac  <= {1'b0, p[31:16]};
        res.clamp <= 1'b0;
      end
    end
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      v1        <= start;
      v2        <= v1;
      v3        <= v2;
      res.valid <= v3;
    end
  end

endmodule

// ===== rtl/tgi_blend.sv =====
// ----------------------------------------------------------------------------
// tgi_blend: one linear blend a*(1-f) + b*f, rounded to nearest
// Two stages: (b-a)*f product, then a plus the rounded Q16 term.
// Ties round toward plus infinity. Tag travels with the beat.
// ----------------------------------------------------------------------------
module tgi_blend (
  input  logic                                clk,
  input  logic                                rst,
  input  tgi_pkg::blend_ctl_t                 req,
  input  logic signed [tgi_pkg::SAMPLE_W-1:0] a,
  input  logic signed [tgi_pkg::SAMPLE_W-1:0] b,
  input  logic [tgi_pkg::FRAC_W-1:0]          f,
  output tgi_pkg::blend_ctl_t                 rsp,
  output logic signed [tgi_pkg::SAMPLE_W-1:0] value
);
  import tgi_pkg::*;

  localparam int PW = SAMPLE_W + 19;

  logic signed [SAMPLE_W:0]   diff;
  logic signed [PW-1:0]       prod;
  logic signed [SAMPLE_W-1:0] a1;
  logic [TAG_W-1:0]           tag1;
  logic                       v1;
  logic signed [PW-1:0]       rnd;

  // stage 1: difference times weight
  assign diff = $signed({b[SAMPLE_W-1], b}) - $signed({a[SAMPLE_W-1], a});

  always_ff @(posedge clk) begin
    if (req.valid) begin
      prod <= PW'(diff) * PW'($signed({1'b0, f}));
      a1   <= a;
      tag1 <= req.tag;
    end
  end

  // stage 2: round and add base; result lies between a and b
  assign rnd = (prod + PW'(32768)) >>> 16;

  always_ff @(posedge clk) begin
    if (v1) begin
      value   <= a1 + rnd[SAMPLE_W-1:0];
      rsp.tag <= tag1;
    end
    if (rst) begin
      v1        <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      v1        <= req.valid;
      rsp.valid <= v1;
    end
  end

endmodule

// ===== rtl/trilinear_grid_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// trilinear_grid_interpolator_unit: 3D grid store with trilinear lookup
// A load beat writes one sample. A query beat holds the input through the
// axis mapping, eight corner reads from the single-port grid memory, the
// seven blends on one shared two-stage blend unit (z, y, x in turn), and
// the pass of the result to the output register.
// The next beat is taken once the block is back in idle, even while the
// last result still waits at the output register; a query that finishes
// while that result is still stalled waits until it leaves.
// The grid memory has no clearing pass; entries are undefined until loaded.
// ----------------------------------------------------------------------------
module trilinear_grid_interpolator_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 cmd,
  input  logic [tgi_pkg::INDEX_W-1:0]          load_index,
  input  logic signed [tgi_pkg::COORD_W-1:0]   load_value,
  input  logic signed [tgi_pkg::COORD_W-1:0]   x_coord,
  input  logic signed [tgi_pkg::COORD_W-1:0]   y_coord,
  input  logic signed [tgi_pkg::COORD_W-1:0]   z_coord,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [tgi_pkg::COORD_W-1:0]   interp_value,
  output logic                                 out_of_range,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tgi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tgi_pkg::COORD_W-1:0]          cfg_data
);
  import tgi_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_AXIS = 4'd1;
  localparam logic [3:0] S_READ = 4'd2;
  localparam logic [3:0] S_WZ   = 4'd3;
  localparam logic [3:0] S_Y    = 4'd4;
  localparam logic [3:0] S_WY   = 4'd5;
  localparam logic [3:0] S_X    = 4'd6;
  localparam logic [3:0] S_WX   = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state;

  // configuration registers
  logic signed [COORD_W-1:0] origin_x, origin_y, origin_z;
  logic [COORD_W-1:0]        inv_step_x, inv_step_y, inv_step_z;

  // handshake
  logic in_acc, query_start, load_ok, mem_we, mem_re;
  logic [31:0] load_ext;

  // axis results
  axis_res_t ax_x, ax_y, ax_z;

  // memory
  logic [SAMPLE_W-1:0] grid_mem [GRID_WORDS];
  logic [SAMPLE_W-1:0] rdata;
  logic [ADDR_W-1:0]   mem_addr;
  logic [31:0]         xi, yi, zi, flat;

  // read sequencing
  logic [2:0] rd_k, rd_k_d;
  logic       rd_pend;
  logic       ysel;
  logic signed [SAMPLE_W-1:0] hold_a;

  // blend unit
  blend_ctl_t                 bl_req, bl_rsp;
  logic signed [SAMPLE_W-1:0] bl_a, bl_b, bl_val;
  logic [FRAC_W-1:0]          bl_f;
  logic signed [SAMPLE_W-1:0] yz0, yz1, yz2, yz3, zx0, zx1, fin;

  assign cfg_ready   = 1'b1;
  assign in_stall    = (state != S_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign query_start = in_acc && (cmd == CMD_QUERY);
  assign load_ext    = 32'(load_index);
  assign load_ok     = load_ext < 32'(GRID_WORDS);
  assign mem_we      = in_acc && (cmd == CMD_LOAD) && load_ok;
  assign mem_re      = (state == S_READ);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x   <= '0;
      origin_y   <= '0;
      origin_z   <= '0;
      inv_step_x <= COORD_W'(ONE_Q16);
      inv_step_y <= COORD_W'(ONE_Q16);
      inv_step_z <= COORD_W'(ONE_Q16);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORIGIN_X:   origin_x   <= cfg_data;
        REG_ORIGIN_Y:   origin_y   <= cfg_data;
        REG_ORIGIN_Z:   origin_z   <= cfg_data;
        REG_INV_STEP_X: inv_step_x <= cfg_data;
        REG_INV_STEP_Y: inv_step_y <= cfg_data;
        REG_INV_STEP_Z: inv_step_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // axis lanes
  tgi_axis u_axis_x (
    .clk(clk), .rst(rst), .start(query_start), .coord(x_coord), .origin(origin_x),
    .inv_step(inv_step_x), .max_cell(CELL_W'(GRID_X - 2)), .res(ax_x)
  );
  tgi_axis u_axis_y (
    .clk(clk), .rst(rst), .start(query_start), .coord(y_coord), .origin(origin_y),
    .inv_step(inv_step_y), .max_cell(CELL_W'(GRID_Y - 2)), .res(ax_y)
  );
  tgi_axis u_axis_z (
    .clk(clk), .rst(rst), .start(query_start), .coord(z_coord), .origin(origin_z),
    .inv_step(inv_step_z), .max_cell(CELL_W'(GRID_Z - 2)), .res(ax_z)
  );

  // corner address: k = {dx, dy, dz}
  assign xi   = 32'(ax_x.base) + 32'(rd_k[2]);
  assign yi   = 32'(ax_y.base) + 32'(rd_k[1]);
  assign zi   = 32'(ax_z.base) + 32'(rd_k[0]);
  assign flat = xi * 32'(GRID_Y * GRID_Z) + yi * 32'(GRID_Z) + zi;

  // single port: loads only in idle, reads only while sweeping corners
  always_comb begin
    if (mem_we) begin
      mem_addr = load_ext[ADDR_W-1:0];
    end else begin
      mem_addr = flat[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_addr] <= load_value[SAMPLE_W-1:0];
    end
    if (mem_re) begin
      rdata <= grid_mem[mem_addr];
    end
  end

  // read data tracking; even corner is held for its z pair
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    rd_k_d <= rd_k;
    if (rd_pend && !rd_k_d[0]) begin
      hold_a <= rdata;
    end
  end

  // blend issue select
  always_comb begin
    bl_req.valid = 1'b0;
    bl_req.tag   = TAG_Z0;
    bl_a         = yz0;
    bl_b         = yz1;
    bl_f         = ax_y.frac;
    if (rd_pend && rd_k_d[0]) begin
      bl_req.valid = 1'b1;
      bl_req.tag   = {1'b0, rd_k_d[2:1]};
      bl_a         = hold_a;
      bl_b         = rdata;
      bl_f         = ax_z.frac;
    end else if (state == S_Y) begin
      bl_req.valid = 1'b1;
      bl_req.tag   = ysel ? TAG_Y1 : TAG_Y0;
      bl_a         = ysel ? yz2 : yz0;
      bl_b         = ysel ? yz3 : yz1;
      bl_f         = ax_y.frac;
    end else if (state == S_X) begin
      bl_req.valid = 1'b1;
      bl_req.tag   = TAG_X;
      bl_a         = zx0;
      bl_b         = zx1;
      bl_f         = ax_x.frac;
    end
  end

  tgi_blend u_blend (
    .clk(clk), .rst(rst), .req(bl_req), .a(bl_a), .b(bl_b), .f(bl_f),
    .rsp(bl_rsp), .value(bl_val)
  );

  // blend results by tag
  always_ff @(posedge clk) begin
    if (bl_rsp.valid) begin
      case (bl_rsp.tag)
        TAG_Z0: yz0 <= bl_val;
        TAG_Z1: yz1 <= bl_val;
        TAG_Z2: yz2 <= bl_val;
        TAG_Z3: yz3 <= bl_val;
        TAG_Y0: zx0 <= bl_val;
        TAG_Y1: zx1 <= bl_val;
        TAG_X:  fin <= bl_val;
        default: ;
      endcase
    end
  end

  // query sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rd_k  <= '0;
      ysel  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (query_start) begin
            state <= S_AXIS;
          end
        end
        S_AXIS: begin
          rd_k <= '0;
          if (ax_x.valid) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          rd_k <= rd_k + 3'd1;
          if (rd_k == 3'd7) begin
            state <= S_WZ;
          end
        end
        S_WZ: begin
          ysel <= 1'b0;
          if (bl_rsp.valid && (bl_rsp.tag == TAG_Z3)) begin
            state <= S_Y;
          end
        end
        S_Y: begin
          ysel <= 1'b1;
          if (ysel) begin
            state <= S_WY;
          end
        end
        S_WY: begin
          if (bl_rsp.valid && (bl_rsp.tag == TAG_Y1)) begin
            state <= S_X;
          end
        end
        S_X: begin
          state <= S_WX;
        end
        S_WX: begin
          if (bl_rsp.valid && (bl_rsp.tag == TAG_X)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!out_valid || !out_stall)) begin
      interp_value <= COORD_W'(fin);
      out_of_range <= ax_x.clamp | ax_y.clamp | ax_z.clamp;
    end
  end

  // checks
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("grid memory read and write in the same cycle");

  a_rd_window: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == S_READ) || (state == S_WZ))
    else $error("corner data outside the read window");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result beat raised without a finished query");

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of trilinear_grid_interpolator_unit
// Loads grid samples and sends query beats under random idling on both
// channels. Each result is checked against a local fixed-point predictor
// of the axis mapping, edge clamping and the seven-step trilinear blend.
// Covers sample and coordinate extremes, all clamp directions, register
// extremes, and random register settings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tgi_pkg::*;

  // writes to these indexes must be accepted and have no effect
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic signed [COORD_W-1:0] Q_MIN     = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] Q_MAX     = 32'sh7FFF_FFFF;
  localparam logic [COORD_W-1:0]        STEP_MIN  = 32'd1;
  localparam logic [COORD_W-1:0]        STEP_MAX  = 32'hFFFF_FFFF;
  localparam logic [COORD_W-1:0]        STEP_UNIT = ONE_Q16;

  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 1000;

  typedef struct {
    int unsigned base;
    int unsigned frac;
    bit          clamp;
  } axis_map_t;

  typedef struct {
    logic signed [COORD_W-1:0] value;
    logic                      clamped;
  } grid_result_t;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic                        cmd;
  logic [INDEX_W-1:0]          load_index;
  logic signed [COORD_W-1:0]   load_value;
  logic signed [COORD_W-1:0]   x_coord;
  logic signed [COORD_W-1:0]   y_coord;
  logic signed [COORD_W-1:0]   z_coord;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [COORD_W-1:0]   interp_value;
  logic                        out_of_range;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [COORD_W-1:0]          cfg_data;

  // predictor state: register copy and grid copy
  logic signed [COORD_W-1:0]   map_origin_x = '0;
  logic signed [COORD_W-1:0]   map_origin_y = '0;
  logic signed [COORD_W-1:0]   map_origin_z = '0;
  logic [COORD_W-1:0]          map_step_x   = ONE_Q16;
  logic [COORD_W-1:0]          map_step_y   = ONE_Q16;
  logic [COORD_W-1:0]          map_step_z   = ONE_Q16;
  logic signed [COORD_W-1:0]   grid_model [GRID_WORDS];
  bit                          sample_written [GRID_WORDS];

  grid_result_t pending_results [$];

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int beats_sent     = 0;
  int loads_sent     = 0;
  int queries_sent   = 0;
  int cfg_writes     = 0;
  int results_seen   = 0;
  int clamped_seen   = 0;
  int idle_cycles    = 0;

  trilinear_grid_interpolator_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .load_index   (load_index),
    .load_value   (load_value),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .z_coord      (z_coord),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .interp_value (interp_value),
    .out_of_range (out_of_range),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned cell_addr(int unsigned x, int unsigned y, int unsigned z);
    return x * GRID_Y * GRID_Z + y * GRID_Z + z;
  endfunction

  // coordinate -> cell index and 0..1.0 weight, clamped to the edge cells
  function automatic axis_map_t map_axis(logic signed [COORD_W-1:0] coord,
                                         logic signed [COORD_W-1:0] origin,
                                         logic [COORD_W-1:0] step, int unsigned size);
    longint    diff;
    bit [63:0] mag;
    bit [63:0] prod;
    axis_map_t m;
    diff = longint'(coord) - longint'(origin);
    mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
    prod = mag * 64'(step);
    m.clamp = 1'b0;
    if (diff < 0 && prod != 0) begin
      m.base  = 0;
      m.frac  = 0;
      m.clamp = 1'b1;
    end else if (prod[63:32] > size - 2) begin
      m.base  = size - 2;
      m.frac  = ONE_Q16;
      m.clamp = 1'b1;
    end else begin
      m.base = prod[63:32];
      m.frac = prod[31:16];
    end
    return m;
  endfunction

  // weighted pair, rounded to nearest with ties up
  function automatic longint mix_pair(longint a, longint b, int unsigned f);
    longint s;
    s = a * (longint'(ONE_Q16) - longint'(f)) + b * longint'(f);
    return (s + 32768) >>> 16;
  endfunction

  function automatic longint sample_at(int unsigned x, int unsigned y, int unsigned z);
    return longint'(grid_model[cell_addr(x, y, z)]);
  endfunction

  function automatic grid_result_t interpolate_point(logic signed [COORD_W-1:0] x,
                                                     logic signed [COORD_W-1:0] y,
                                                     logic signed [COORD_W-1:0] z);
    axis_map_t    mx, my, mz;
    longint       along_z [4];
    longint       along_y [2];
    longint       blended;
    grid_result_t r;
    int           k;
    mx = map_axis(x, map_origin_x, map_step_x, GRID_X);
    my = map_axis(y, map_origin_y, map_step_y, GRID_Y);
    mz = map_axis(z, map_origin_z, map_step_z, GRID_Z);
    for (k = 0; k < 4; k++) begin
      along_z[k] = mix_pair(sample_at(mx.base + k / 2, my.base + k % 2, mz.base),
                            sample_at(mx.base + k / 2, my.base + k % 2, mz.base + 1),
                            mz.frac);
    end
    along_y[0] = mix_pair(along_z[0], along_z[1], my.frac);
    along_y[1] = mix_pair(along_z[2], along_z[3], my.frac);
    blended    = mix_pair(along_y[0], along_y[1], mx.frac);
    r.value    = blended[31:0];
    r.clamped  = mx.clamp | my.clamp | mz.clamp;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  // grid position (Q16.16) -> coordinate under the given mapping, saturated
  function automatic logic signed [COORD_W-1:0] aim_coord(logic signed [COORD_W-1:0] origin,
                                                          logic [COORD_W-1:0] step,
                                                          longint pos);
    longint c;
    c = longint'(origin) + (pos * 65536) / longint'({32'd0, step});
    if (c > longint'(Q_MAX)) c = longint'(Q_MAX);
    if (c < longint'(Q_MIN)) c = longint'(Q_MIN);
    return c[31:0];
  endfunction

  // mostly inside the grid, some on the edges, some just past, some anywhere
  function automatic logic signed [COORD_W-1:0] pick_coord(logic signed [COORD_W-1:0] origin,
                                                           logic [COORD_W-1:0] step,
                                                           int unsigned size);
    int unsigned roll;
    longint      pos;
    longint      last;
    roll = $urandom_range(99);
    last = longint'(size - 1) * ONE_Q16;
    if (roll < 10) return $urandom();
    if (roll < 25) begin
      case ($urandom_range(4))
        0:       pos = 0;
        1:       pos = last;
        2:       pos = -1;
        3:       pos = last - 1;
        default: pos = last + 1;
      endcase
    end else if (roll < 40) begin
      pos = longint'($urandom_range(0, (size + 8) * ONE_Q16)) - 4 * ONE_Q16;
    end else begin
      pos = $urandom_range(0, last);
    end
    return aim_coord(origin, step, pos);
  endfunction

  function automatic logic [COORD_W-1:0] rand_step();
    logic [COORD_W-1:0] v;
    do v = $urandom(); while (v == 0);
    return v;
  endfunction

  // one input beat; the beat is taken at the edge where stall was low
  task automatic send_beat(input logic op, input logic [INDEX_W-1:0] idx,
                           input logic signed [COORD_W-1:0] value,
                           input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y,
                           input logic signed [COORD_W-1:0] z);
    bit taken;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= op;
    load_index <= idx;
    load_value <= value;
    x_coord    <= x;
    y_coord    <= y;
    z_coord    <= z;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    beats_sent++;
    if (op == CMD_LOAD) begin
      grid_model[idx]     = value;
      sample_written[idx] = 1'b1;
      loads_sent++;
    end else begin
      pending_results.push_back(interpolate_point(x, y, z));
      queries_sent++;
    end
  endtask

  // load any unwritten corner of the target cell, then query
  task automatic query_point(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic signed [COORD_W-1:0] z);
    axis_map_t   mx, my, mz;
    int unsigned a;
    int          k;
    mx = map_axis(x, map_origin_x, map_step_x, GRID_X);
    my = map_axis(y, map_origin_y, map_step_y, GRID_Y);
    mz = map_axis(z, map_origin_z, map_step_z, GRID_Z);
    for (k = 0; k < 8; k++) begin
      a = cell_addr(mx.base + k / 4, my.base + (k / 2) % 2, mz.base + k % 2);
      if (!sample_written[a])
        send_beat(CMD_LOAD, a, $urandom(), $urandom(), $urandom(), $urandom());
    end
    send_beat(CMD_QUERY, $urandom_range(GRID_WORDS - 1), $urandom(), x, y, z);
  endtask

  task automatic drive_traffic(input int n);
    int start;
    logic signed [COORD_W-1:0] x, y, z;
    start = beats_sent;
    while (beats_sent - start < n) begin
      if ($urandom_range(99) < 25) begin
        send_beat(CMD_LOAD, $urandom_range(GRID_WORDS - 1), $urandom(),
                  $urandom(), $urandom(), $urandom());
      end else begin
        x = pick_coord(map_origin_x, map_step_x, GRID_X);
        y = pick_coord(map_origin_y, map_step_y, GRID_Y);
        z = pick_coord(map_origin_z, map_step_z, GRID_Z);
        query_point(x, y, z);
      end
    end
  endtask

  // wait until every result is back and the block has gone quiet
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_writes++;
    case (idx)
      REG_ORIGIN_X:   map_origin_x = data;
      REG_ORIGIN_Y:   map_origin_y = data;
      REG_ORIGIN_Z:   map_origin_z = data;
      REG_INV_STEP_X: map_step_x   = data;
      REG_INV_STEP_Y: map_step_y   = data;
      REG_INV_STEP_Z: map_step_z   = data;
      default: ;
    endcase
  endtask

  task automatic program_map(input logic signed [COORD_W-1:0] ox, oy, oz,
                             input logic [COORD_W-1:0] sx, sy, sz);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_INV_STEP_X, sx);
    write_reg(REG_INV_STEP_Y, sy);
    write_reg(REG_INV_STEP_Z, sz);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  // extreme sample values on cell 0; exact corner, midpoint and odd fractions
  task automatic test_sample_extremes();
    logic signed [COORD_W-1:0] corner_vals [8] = '{Q_MIN, Q_MAX, Q_MAX, Q_MIN,
                                                   32'sd0, -32'sd1, 32'sd1, Q_MIN};
    int k;
    for (k = 0; k < 8; k++)
      send_beat(CMD_LOAD, cell_addr(k / 4, (k / 2) % 2, k % 2), corner_vals[k],
                $urandom(), $urandom(), $urandom());
    query_point(32'sd0, 32'sd0, 32'sd0);
    query_point(32'sd32768, 32'sd32768, 32'sd32768);
    query_point(32'sd65535, 32'sd1, 32'sd40000);
  endtask

  // below the grid, past it, exactly on the last center, and just inside
  task automatic test_edge_clamping();
    logic signed [COORD_W-1:0] last_x, last_y, last_z;
    last_x = (GRID_X - 1) * ONE_Q16;
    last_y = (GRID_Y - 1) * ONE_Q16;
    last_z = (GRID_Z - 1) * ONE_Q16;
    query_point(-32'sd1, -32'sd1, -32'sd1);
    query_point(Q_MIN, Q_MIN, Q_MIN);
    query_point(last_x, last_y, last_z);
    query_point(Q_MAX, Q_MAX, Q_MAX);
    query_point(last_x - 32768, last_y - 1, last_z - 32768);
  endtask

  // register extremes, mixed per axis, plus writes to unused indexes
  task automatic test_register_extremes();
    settle_block();
    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_SPARE_HI, $urandom());
    program_map(Q_MIN, Q_MIN, Q_MIN, STEP_MAX, STEP_MAX, STEP_MAX);
    drive_traffic(30);
    settle_block();
    program_map(Q_MAX, Q_MAX, Q_MAX, STEP_MIN, STEP_MIN, STEP_MIN);
    drive_traffic(30);
    settle_block();
    program_map(Q_MIN, 32'sd0, Q_MAX, STEP_MIN, STEP_UNIT, STEP_MAX);
    drive_traffic(30);
    settle_block();
    program_map(Q_MAX, Q_MIN, 32'sd0, STEP_MAX, STEP_MIN, STEP_UNIT);
    drive_traffic(30);
  endtask

  // four register settings: unit grid, two scaled grids, fully random
  task automatic test_mapped_traffic(input int n);
    int round;
    for (round = 0; round < 4; round++) begin
      settle_block();
      case (round)
        0: program_map(32'sd0, 32'sd0, 32'sd0, STEP_UNIT, STEP_UNIT, STEP_UNIT);
        1, 2: program_map(int'($urandom_range(0, 64 * ONE_Q16)) - 32 * ONE_Q16,
                          int'($urandom_range(0, 64 * ONE_Q16)) - 32 * ONE_Q16,
                          int'($urandom_range(0, 64 * ONE_Q16)) - 32 * ONE_Q16,
                          $urandom_range(1 << 13, 1 << 19),
                          $urandom_range(1 << 13, 1 << 19),
                          $urandom_range(1 << 13, 1 << 19));
        default: program_map($urandom(), $urandom(), $urandom(),
                             rand_step(), rand_step(), rand_step());
      endcase
      drive_traffic(n / 4);
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    cmd        <= CMD_LOAD;
    load_index <= '0;
    load_value <= '0;
    x_coord    <= '0;
    y_coord    <= '0;
    z_coord    <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_ORIGIN_X;
    cfg_data   <= '0;
    out_stall  <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_gap_pct   = 24;
    recv_stall_pct = 67;
    test_sample_extremes();
    test_edge_clamping();
    test_register_extremes();
    test_mapped_traffic(520);

    send_gap_pct   = 67;
    recv_stall_pct = 24;
    test_mapped_traffic(480);

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_mapped_traffic(480);

    settle_block();
    $display("Run covered %0d loads and %0d queries over %0d register writes.",
             loads_sent, queries_sent, cfg_writes);
    $display("Checked %0d results, %0d of them clamped to the grid edge.",
             results_seen, clamped_seen);
    if (error_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------- result side

  // receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // compare each result beat with the oldest prediction
  always @(negedge clk) begin
    grid_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with no query outstanding: interp_value %0d", interp_value);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (want.clamped) clamped_seen++;
        if (interp_value !== want.value) begin
          $error("interp_value: expected %0d, got %0d", want.value, interp_value);
          error_count++;
        end
        if (out_of_range !== want.clamped) begin
          $error("out_of_range: expected %0b, got %0b", want.clamped, out_of_range);
          error_count++;
        end
      end
    end
  end

  // watchdog: ends the run if no beat moves on any channel for too long
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("tb failed");
        $finish;
      end
    end
  end

endmodule

// ===== trilinear_grid_interpolator_unit.f =====
rtl/tgi_pkg.sv
rtl/tgi_axis.sv
rtl/tgi_blend.sv
rtl/trilinear_grid_interpolator_unit.sv
tb/sv/tb.sv
